// ===== rtl/alt_pkg.sv =====
package alt_pkg;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [1:0] KIND_LABEL    = 2'd0;
  localparam logic [1:0] KIND_MNEMONIC = 2'd1;
  localparam logic [1:0] KIND_OPERAND  = 2'd2;
  localparam logic [1:0] KIND_STATUS   = 2'd3;

  localparam logic [1:0] STAT_NONE  = 2'd0;
  localparam logic [1:0] STAT_INSTR = 2'd1;
  localparam logic [1:0] STAT_ERROR = 2'd2;

  typedef enum logic [5:0] {
    PH_WAIT_HEAD = 6'b000001,
    PH_HEAD      = 6'b000010,
    PH_WAIT_OP   = 6'b000100,
    PH_OPERAND   = 6'b001000,
    PH_OVERFLOW  = 6'b010000,
    PH_SKIP      = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] start_res;
    logic [4:0] length;
    logic [1:0] operand_index;
    logic [1:0] status;
    logic       last;
  } res_t;

  // up to two result words per accepted character, slot 0 filled first
  typedef struct packed {
    logic v0;
    logic v1;
    res_t r0;
    res_t r1;
  } push_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic ident_first(input logic [7:0] c);
    return (c == CH_UNDER) || (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
  endfunction

  function automatic logic ident_rest(input logic [7:0] c);
    return ident_first(c) || (c >= 8'd48 && c <= 8'd57);
  endfunction

endpackage

// ===== rtl/assembly_line_tokenizer.sv =====
// assembly line tokenizer
// input channel: one line character per word (ch, line_end), in_valid/in_ready.
// line_end marks the last character of a line; a blank line is a single space.
// output channel: one descriptor per word (kind, start_res, length, operand_index,
// status, last), out_valid/out_ready. each line gives an optional label, the
// mnemonic if it has one and the kept operands, then one status word with last set.
// a word produced by a character is written into the output queue when that
// character is accepted, and reaches the output once the words ahead of it have left.
// throughput: one character per cycle while the output drains; a character that
// closes a token on the line's last position yields two words, which leave one
// after the other through the four-word output queue.
// in_ready depends only on the queue fill: it is high while at most two words
// wait, so a stalled receiver holds back the input after the queue fills.
// reset clears the line state and empties the queue; the next character is
// offset zero of a new line. on an error the consumer drops that line's words.
module assembly_line_tokenizer #(
  parameter int MAX_LINE     = 256,
  parameter int MAX_TOKEN    = 32,
  parameter int MAX_OPERANDS = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] ch,
  input  logic       line_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] kind,
  output logic [7:0] start_res,
  output logic [4:0] length,
  output logic [1:0] operand_index,
  output logic [1:0] status,
  output logic       last
);

  alt_pkg::push_t push;
  alt_pkg::res_t  res;
  logic           accept;

  assign accept = in_valid & in_ready;

  alt_core #(
    .MAX_LINE     (MAX_LINE),
    .MAX_TOKEN    (MAX_TOKEN),
    .MAX_OPERANDS (MAX_OPERANDS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .ch       (ch),
    .line_end (line_end),
    .push     (push)
  );

  alt_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign kind          = res.kind;
  assign start_res     = res.start_res;
  assign length        = res.length;
  assign operand_index = res.operand_index;
  assign status        = res.status;
  assign last          = res.last;

endmodule

// ===== rtl/alt_core.sv =====
module alt_core #(
  parameter int MAX_LINE     = 256,
  parameter int MAX_TOKEN    = 32,
  parameter int MAX_OPERANDS = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       ch,
  input  logic             line_end,
  output alt_pkg::push_t   push
);

  localparam int PW  = $clog2(MAX_LINE);
  localparam int QW  = $clog2(MAX_LINE + 1);
  localparam int MTW = $clog2(MAX_TOKEN + 1);
  localparam int TW  = (QW > MTW) ? QW : MTW;
  localparam int KW  = $clog2(MAX_OPERANDS + 1);

  alt_pkg::phase_t phase, phase_next;
  logic [QW-1:0]   position, position_next;
  logic [PW-1:0]   token_start, token_start_next;
  logic [PW-1:0]   last_nonspace, last_nonspace_next;
  logic            head_is_ident, head_is_ident_next;
  logic            label_taken, label_taken_next;
  logic [KW-1:0]   kept_operands, kept_operands_next;
  logic            line_error, line_error_next;
  logic            mnem_seen, mnem_seen_next;

  logic            ws, stray, hash, comma;
  logic [PW-1:0]   cur;
  logic [TW-1:0]   len_a, len_b;
  logic            big_a, big_b;
  logic [KW-1:0]   ko_inc;
  alt_pkg::res_t   tmp;
  alt_pkg::push_t  out_p;

  always_comb begin
    phase_next         = phase;
    position_next      = position;
    token_start_next   = token_start;
    last_nonspace_next = last_nonspace;
    head_is_ident_next = head_is_ident;
    label_taken_next   = label_taken;
    kept_operands_next = kept_operands;
    line_error_next    = line_error;
    mnem_seen_next     = mnem_seen;
    out_p              = '0;
    tmp                = '0;

    ws     = alt_pkg::is_ws(ch);
    hash   = (ch == alt_pkg::CH_HASH);
    comma  = (ch == alt_pkg::CH_COMMA);
    stray  = (ch == alt_pkg::CH_COLON) && !label_taken;
    cur    = position[PW-1:0];
    len_a  = TW'(last_nonspace) - TW'(token_start) + TW'(1);
    big_a  = (len_a >= TW'(MAX_TOKEN));
    ko_inc = kept_operands + KW'(1);

    if (position == QW'(MAX_LINE)) begin
      line_error_next = 1'b1;
    end else begin
      position_next = position + QW'(1);
      if (!line_error) begin
        case (phase)
          alt_pkg::PH_WAIT_HEAD: begin
            if (!ws) begin
              if (hash) begin
                phase_next = alt_pkg::PH_SKIP;
              end else if (stray) begin
                line_error_next = 1'b1;
              end else begin
                token_start_next   = cur;
                last_nonspace_next = cur;
                head_is_ident_next = alt_pkg::ident_first(ch);
                phase_next         = alt_pkg::PH_HEAD;
              end
            end
          end
          alt_pkg::PH_HEAD: begin
            if (ws || hash) begin
              mnem_seen_next = 1'b1;
              if (big_a) begin
                line_error_next = 1'b1;
              end else begin
                out_p.v0              = 1'b1;
                out_p.r0.kind         = alt_pkg::KIND_MNEMONIC;
                out_p.r0.start_res    = 8'(token_start);
                out_p.r0.length       = 5'(len_a);
              end
              phase_next = ws ? alt_pkg::PH_WAIT_OP : alt_pkg::PH_SKIP;
            end else if (stray) begin
              // colon closing the first token: label if it is a clean identifier
              if (head_is_ident && !big_a) begin
                out_p.v0           = 1'b1;
                out_p.r0.kind      = alt_pkg::KIND_LABEL;
                out_p.r0.start_res = 8'(token_start);
                out_p.r0.length    = 5'(len_a);
                label_taken_next   = 1'b1;
                phase_next         = alt_pkg::PH_WAIT_HEAD;
              end else begin
                line_error_next = 1'b1;
              end
            end else begin
              last_nonspace_next = cur;
              if (!alt_pkg::ident_rest(ch)) head_is_ident_next = 1'b0;
            end
          end
          alt_pkg::PH_WAIT_OP: begin
            if (!(ws || comma)) begin
              if (hash) begin
                phase_next = alt_pkg::PH_SKIP;
              end else if (stray) begin
                line_error_next = 1'b1;
              end else begin
                token_start_next   = cur;
                last_nonspace_next = cur;
                phase_next         = alt_pkg::PH_OPERAND;
              end
            end
          end
          alt_pkg::PH_OPERAND: begin
            if (comma || hash) begin
              if (big_a) begin
                line_error_next = 1'b1;
              end else begin
                out_p.v0               = 1'b1;
                out_p.r0.kind          = alt_pkg::KIND_OPERAND;
                out_p.r0.start_res     = 8'(token_start);
                out_p.r0.length        = 5'(len_a);
                out_p.r0.operand_index = 2'(kept_operands);
                kept_operands_next     = ko_inc;
                phase_next = (ko_inc >= KW'(MAX_OPERANDS)) ? alt_pkg::PH_OVERFLOW
                                                            : alt_pkg::PH_WAIT_OP;
              end
              if (hash) phase_next = alt_pkg::PH_SKIP;
            end else if (ws) begin
              // trailing whitespace is trimmed
            end else if (stray) begin
              line_error_next = 1'b1;
            end else begin
              last_nonspace_next = cur;
            end
          end
          alt_pkg::PH_OVERFLOW: begin
            if (stray) line_error_next = 1'b1;
            else if (hash) phase_next = alt_pkg::PH_SKIP;
          end
          default: begin
          end
        endcase
      end
    end

    // end of line: close an open token, then the status word
    len_b = TW'(last_nonspace_next) - TW'(token_start_next) + TW'(1);
    big_b = (len_b >= TW'(MAX_TOKEN));
    if (line_end) begin
      if (!line_error_next) begin
        if (phase_next == alt_pkg::PH_HEAD) begin
          mnem_seen_next = 1'b1;
          if (big_b) begin
            line_error_next = 1'b1;
          end else begin
            out_p.v0           = 1'b1;
            out_p.r0.kind      = alt_pkg::KIND_MNEMONIC;
            out_p.r0.start_res = 8'(token_start_next);
            out_p.r0.length    = 5'(len_b);
          end
        end else if (phase_next == alt_pkg::PH_OPERAND) begin
          if (big_b) begin
            line_error_next = 1'b1;
          end else begin
            out_p.v0               = 1'b1;
            out_p.r0.kind          = alt_pkg::KIND_OPERAND;
            out_p.r0.start_res     = 8'(token_start_next);
            out_p.r0.length        = 5'(len_b);
            out_p.r0.operand_index = 2'(kept_operands_next);
          end
        end
      end
      tmp.kind   = alt_pkg::KIND_STATUS;
      tmp.last   = 1'b1;
      tmp.status = line_error_next ? alt_pkg::STAT_ERROR :
                   (mnem_seen_next ? alt_pkg::STAT_INSTR : alt_pkg::STAT_NONE);
      if (out_p.v0) begin
        out_p.v1 = 1'b1;
        out_p.r1 = tmp;
      end else begin
        out_p.v0 = 1'b1;
        out_p.r0 = tmp;
      end
      phase_next         = alt_pkg::PH_WAIT_HEAD;
      position_next      = '0;
      token_start_next   = '0;
      last_nonspace_next = '0;
      head_is_ident_next = 1'b1;
      label_taken_next   = 1'b0;
      kept_operands_next = '0;
      line_error_next    = 1'b0;
      mnem_seen_next     = 1'b0;
    end

    push    = out_p;
    push.v0 = out_p.v0 & accept;
    push.v1 = out_p.v1 & accept;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= alt_pkg::PH_WAIT_HEAD;
      position      <= '0;
      token_start   <= '0;
      last_nonspace <= '0;
      head_is_ident <= 1'b1;
      label_taken   <= 1'b0;
      kept_operands <= '0;
      line_error    <= 1'b0;
      mnem_seen     <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      position      <= position_next;
      token_start   <= token_start_next;
      last_nonspace <= last_nonspace_next;
      head_is_ident <= head_is_ident_next;
      label_taken   <= label_taken_next;
      kept_operands <= kept_operands_next;
      line_error    <= line_error_next;
      mnem_seen     <= mnem_seen_next;
    end
  end

endmodule

// ===== rtl/alt_fifo.sv =====
module alt_fifo (
  input  logic            clk,
  input  logic            rst,
  input  alt_pkg::push_t  push,
  output logic            space,
  output logic            out_valid,
  input  logic            out_ready,
  output alt_pkg::res_t   out_res
);

  alt_pkg::res_t mem [4];
  logic [1:0]    wp, rp;
  logic [2:0]    count, count_next;
  logic          pop;
  logic [1:0]    n_push;

  assign pop        = out_valid & out_ready;
  assign n_push     = {1'b0, push.v0} + {1'b0, push.v1};
  assign count_next = count + {1'b0, n_push} - {2'b00, pop};
  // room for the two words a single character can produce
  assign space      = (count <= 3'd2);
  assign out_valid  = (count != 3'd0);
  assign out_res    = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + n_push;
      rp    <= rp + {1'b0, pop};
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.v0) mem[wp] <= push.r0;
    if (push.v1) mem[wp + 2'd1] <= push.r1;
  end

endmodule
